FILE: hw/rtl/b64d_pkg.sv
// Shared types and constants for the base64 128-bit value decoder.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // Character codes of the alphabet ranges and the pad character.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Offsets of the lower-case letters and the digits within the alphabet.
    localparam logic [5:0] CODE_LOWER_BASE = 6'd26;
    localparam logic [5:0] CODE_DIGIT_BASE = 6'd52;
    localparam logic [5:0] CODE_PLUS       = 6'd62;
    localparam logic [5:0] CODE_SLASH      = 6'd63;

    // Capacity of the decoded value in bytes.
    localparam logic [4:0] VALUE_BYTES = 5'd16;

    // Classification of one incoming character.
    typedef struct packed {
        logic       is_pad;
        logic       is_code;
        logic [5:0] code;
    } t_sym_info;

endpackage

`default_nettype wire

FILE: hw/rtl/b64d_if.sv
// Valid/ready channel interfaces for characters in and decoded values out.
`timescale 1ns / 1ps
`default_nettype none

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink (input valid, input symbol, input last, output ready);
endinterface

interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic        overflow;

    modport source (output valid, output value_low, output value_high, output overflow,
                    input ready);
    modport sink (input valid, input value_low, input value_high, input overflow,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/b64d_lookup.sv
// Character classifier: maps a character onto its 6-bit base64 code.
`timescale 1ns / 1ps
`default_nettype none

module b64d_lookup (
    input  wire logic [7:0]         i_symbol,
    output b64d_pkg::t_sym_info     o_info
);

    // Range checks on the alphabet; codes at or above 128 fall through as invalid.
    always_comb begin
        o_info = '0;
        priority if (i_symbol == b64d_pkg::CHAR_PAD) begin
            o_info.is_pad = 1'b1;
        end else if (i_symbol >= b64d_pkg::CHAR_UPPER_A && i_symbol <= b64d_pkg::CHAR_UPPER_Z) begin
            o_info.is_code = 1'b1;
            o_info.code    = 6'(i_symbol - b64d_pkg::CHAR_UPPER_A);
        end else if (i_symbol >= b64d_pkg::CHAR_LOWER_A && i_symbol <= b64d_pkg::CHAR_LOWER_Z) begin
            o_info.is_code = 1'b1;
            o_info.code    = 6'(i_symbol - b64d_pkg::CHAR_LOWER_A) + b64d_pkg::CODE_LOWER_BASE;
        end else if (i_symbol >= b64d_pkg::CHAR_DIGIT_0 && i_symbol <= b64d_pkg::CHAR_DIGIT_9) begin
            o_info.is_code = 1'b1;
            o_info.code    = 6'(i_symbol - b64d_pkg::CHAR_DIGIT_0) + b64d_pkg::CODE_DIGIT_BASE;
        end else if (i_symbol == b64d_pkg::CHAR_PLUS) begin
            o_info.is_code = 1'b1;
            o_info.code    = b64d_pkg::CODE_PLUS;
        end else if (i_symbol == b64d_pkg::CHAR_SLASH) begin
            o_info.is_code = 1'b1;
            o_info.code    = b64d_pkg::CODE_SLASH;
        end else begin
            o_info = '0;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/b64d_core.sv
// Decoder state: group accumulator, byte packing into the 128-bit value.
`timescale 1ns / 1ps
`default_nettype none

module b64d_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic                i_last,
    input  wire b64d_pkg::t_sym_info i_info,
    output logic [127:0]             o_value,
    output logic                     o_overflow
);

    logic [23:0]  r_acc;
    logic [1:0]   r_group_count;
    logic [127:0] r_value;
    logic [4:0]   r_byte_count;
    logic         r_stopped;
    logic         r_overflowed;

    logic [23:0]  n_acc;
    logic [1:0]   n_group_count;
    logic [127:0] n_value;
    logic [4:0]   n_byte_count;
    logic         n_stopped;
    logic         n_overflowed;

    logic [23:0]  acc_shifted;
    logic [23:0]  new_bytes;
    logic [1:0]   new_count;
    logic [5:0]   total_bytes;
    logic         drop;

    // Fold the character into the group and gather the bytes it releases.
    // The first byte released lands in the low byte of new_bytes.
    always_comb begin
        acc_shifted   = {r_acc[17:0], i_info.code};
        n_acc         = r_acc;
        n_group_count = r_group_count;
        n_stopped     = r_stopped;
        new_bytes     = '0;
        new_count     = 2'd0;
        if (!r_stopped) begin
            if (i_info.is_pad) begin
                n_stopped = 1'b1;
            end else if (i_info.is_code) begin
                if (r_group_count == 2'd3) begin
                    new_bytes     = {acc_shifted[7:0], acc_shifted[15:8], acc_shifted[23:16]};
                    new_count     = 2'd3;
                    n_acc         = '0;
                    n_group_count = 2'd0;
                end else begin
                    n_acc         = acc_shifted;
                    n_group_count = r_group_count + 2'd1;
                end
            end
        end
        // A partial group at the end of the string yields one or two bytes.
        if (i_last) begin
            priority if (n_group_count == 2'd2) begin
                new_bytes = {16'd0, n_acc[11:4]};
                new_count = 2'd1;
            end else if (n_group_count == 2'd3) begin
                new_bytes = {8'd0, n_acc[9:2], n_acc[17:10]};
                new_count = 2'd2;
            end else begin
                new_bytes = new_bytes;
                new_count = new_count;
            end
        end
    end

    // Place the new bytes at the fill position; bytes past the top are dropped.
    always_comb begin
        total_bytes  = 6'(r_byte_count) + 6'(new_count);
        drop         = total_bytes > 6'(b64d_pkg::VALUE_BYTES);
        n_value      = r_value | (128'(new_bytes) << {r_byte_count, 3'b000});
        n_byte_count = drop ? b64d_pkg::VALUE_BYTES : total_bytes[4:0];
        n_overflowed = r_overflowed | drop;
    end

    assign o_value    = n_value;
    assign o_overflow = n_overflowed;

    // State update; the last character of a string returns everything to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc         <= '0;
            r_group_count <= '0;
            r_value       <= '0;
            r_byte_count  <= '0;
            r_stopped     <= 1'b0;
            r_overflowed  <= 1'b0;
        end else if (i_step) begin
            if (i_last) begin
                r_acc         <= '0;
                r_group_count <= '0;
                r_value       <= '0;
                r_byte_count  <= '0;
                r_stopped     <= 1'b0;
                r_overflowed  <= 1'b0;
            end else begin
                r_acc         <= n_acc;
                r_group_count <= n_group_count;
                r_value       <= n_value;
                r_byte_count  <= n_byte_count;
                r_stopped     <= n_stopped;
                r_overflowed  <= n_overflowed;
            end
        end
    end

    // The fill position never runs past the capacity of the value.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= b64d_pkg::VALUE_BYTES)
        else $error("byte count beyond capacity");

    // The end of a string clears the group and the fill position.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last |=> r_byte_count == 5'd0 && r_group_count == 2'd0 && !r_stopped)
        else $error("state not cleared after last item");

    // Once stopped, the group does not move until the string ends.
    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_last && r_stopped |=> r_stopped && $stable(r_group_count))
        else $error("decoding continued after pad");

    // The overflow mark stays until the string ends.
    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_last && r_overflowed |=> r_overflowed)
        else $error("overflow mark lost");

endmodule

`default_nettype wire

FILE: hw/rtl/base64_decode_128bit_value_unit.sv
// Top level of the base64 decoder that gathers a string into a 128-bit value.
//
// Usage: characters arrive one item per cycle on the i_sym channel (symbol,
// last) while i_sym.ready is high. Characters outside the base64 alphabet
// are skipped, a '=' ends decoding for the rest of the string, and the item
// with last set closes the string. For each closed string one item leaves
// on the o_res channel with the decoded bytes (byte 0 in the low bits of
// value_low) and an overflow flag that is set when more than sixteen bytes
// were decoded. An accepted item is held in the input register, and its
// result is registered in the result register before it is valid on o_res.
// Throughput: one character per cycle while o_res is not stalled, set by the
// single decode step between the input register and the result register.
// Reset clears the decode state and both channel registers; no result is
// pending afterward. When the receiver stalls a pending result, the input
// register takes one more item only if it is empty, and i_sym.ready stays
// low while it holds an item until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module base64_decode_128bit_value_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b64d_in_if.sink     i_sym,
    b64d_out_if.source  o_res
);

    logic                r_in_valid;
    logic [7:0]          r_in_symbol;
    logic                r_in_last;
    logic                r_out_valid;
    logic [63:0]         r_out_low;
    logic [63:0]         r_out_high;
    logic                r_out_overflow;

    logic                stall;
    logic                step;
    b64d_pkg::t_sym_info sym_info;
    logic [127:0]        value;
    logic                overflow;

    // Handshake: the decode step waits only while a result is held up.
    assign stall       = r_out_valid && !o_res.ready;
    assign step        = r_in_valid && !stall;
    assign i_sym.ready = !r_in_valid || !stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sym.ready) begin
            r_in_valid <= i_sym.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sym.valid && i_sym.ready) begin
            r_in_symbol <= i_sym.symbol;
            r_in_last   <= i_sym.last;
        end
    end

    b64d_lookup u_lookup (
        .i_symbol (r_in_symbol),
        .o_info   (sym_info)
    );

    b64d_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_last     (r_in_last),
        .i_info     (sym_info),
        .o_value    (value),
        .o_overflow (overflow)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!stall) begin
            r_out_valid <= step && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_low      <= value[63:0];
            r_out_high     <= value[127:64];
            r_out_overflow <= overflow;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.value_low  = r_out_low;
    assign o_res.value_high = r_out_high;
    assign o_res.overflow   = r_out_overflow;

endmodule

`default_nettype wire
